FILE: hdl/hsc_pkg.sv
// ----------------------------------------------------------------------------
// hsc_pkg
// Shared types, widths and bit-level functions of the Hamming SEC codec.
// ----------------------------------------------------------------------------
package hsc_pkg;

	localparam int CW_W          = 31;  // codeword width, bit 0 = position 1
	localparam int DATA_W        = 26;  // data bits that fit in a 31-bit codeword
	localparam int SYN_W         = 5;   // syndrome width
	localparam int CFG_W         = 5;   // data_bits register width
	localparam int PC_W          = 3;   // parity count width
	localparam int IN_TDATA_W    = 32;
	localparam int OUT_TDATA_W   = 48;
	localparam int OUT_PAD_W     = OUT_TDATA_W - (CW_W + SYN_W + 2 + PC_W);
	localparam int MAX_DATA_BITS = 26;

	localparam logic [CFG_W-1:0] DATA_BITS_RESET = CFG_W'(4);
	localparam logic [CFG_W-1:0] DATA_BITS_MIN   = CFG_W'(1);
	localparam logic [CFG_W-1:0] DATA_BITS_MAX   = CFG_W'(MAX_DATA_BITS);

	typedef enum logic {
		CMD_ENCODE = 1'b0,
		CMD_DECODE = 1'b1
	} cmd_t;

	// Active code geometry, derived from the data_bits register
	typedef struct packed {
		logic [CFG_W-1:0] m;
		logic [SYN_W-1:0] n;
		logic [PC_W-1:0]  r;
	} cfg_t;

	// One result item
	typedef struct packed {
		logic [CW_W-1:0]  codeword;
		logic [SYN_W-1:0] syndrome;
		logic             error_found;
		logic             syndrome_oor;
		logic [PC_W-1:0]  parity_count;
	} result_t;

	// Clamp the register value to the supported range of m
	function automatic logic [CFG_W-1:0] eff_m(input logic [CFG_W-1:0] v);
		logic [CFG_W-1:0] m;
		m = v;
		if (m < DATA_BITS_MIN) m = DATA_BITS_MIN;
		if (m > DATA_BITS_MAX) m = DATA_BITS_MAX;
		return m;
	endfunction

	// Least r with 2^r >= m + r + 1, for m in 1..26
	function automatic logic [PC_W-1:0] parity_bits_for(input logic [CFG_W-1:0] m);
		logic [PC_W-1:0] r;
		if (m <= CFG_W'(1))       r = PC_W'(2);
		else if (m <= CFG_W'(4))  r = PC_W'(3);
		else if (m <= CFG_W'(11)) r = PC_W'(4);
		else                      r = PC_W'(5);
		return r;
	endfunction

	// XOR of the positions of all set bits
	function automatic logic [SYN_W-1:0] syndrome_of(input logic [CW_W-1:0] w);
		logic [SYN_W-1:0] s;
		s = '0;
		for (int p = 1; p <= CW_W; p++) begin
			if (w[p-1]) s = s ^ SYN_W'(p);
		end
		return s;
	endfunction

	// Place data bits, LSB first, in the non-power-of-two positions
	function automatic logic [CW_W-1:0] spread_data(input logic [DATA_W-1:0] d);
		logic [CW_W-1:0] cw;
		int              k;
		cw = '0;
		k  = 0;
		for (int p = 1; p <= CW_W; p++) begin
			if ((p & (p - 1)) != 0) begin
				cw[p-1] = d[k];
				k++;
			end
		end
		return cw;
	endfunction

	// Put syndrome bit i at position 2^i
	function automatic logic [CW_W-1:0] place_parity(input logic [SYN_W-1:0] s);
		logic [CW_W-1:0] cw;
		cw = '0;
		for (int i = 0; i < SYN_W; i++) begin
			cw[(1 << i) - 1] = s[i];
		end
		return cw;
	endfunction

endpackage

FILE: hdl/hsc_cfg.sv
// ----------------------------------------------------------------------------
// hsc_cfg
// data_bits register and the code geometry (m, n, r) derived from it.
// ----------------------------------------------------------------------------
module hsc_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [hsc_pkg::CFG_W-1:0] cfg_wdata,
	output hsc_pkg::cfg_t             cfg
);
	import hsc_pkg::*;

	logic [CFG_W-1:0] data_bits_q;
	logic [CFG_W-1:0] m;
	logic [PC_W-1:0]  r;

	// Hold the register value until the next write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_bits_q <= DATA_BITS_RESET;
		end else if (cfg_we) begin
			data_bits_q <= cfg_wdata;
		end
	end

	// Clamp m and look up r; n = m + r stays within 31
	always_comb begin
		m     = eff_m(data_bits_q);
		r     = parity_bits_for(m);
		cfg.m = m;
		cfg.r = r;
		cfg.n = SYN_W'(m) + SYN_W'(r);
	end

endmodule

FILE: hdl/hsc_core.sv
// ----------------------------------------------------------------------------
// hsc_core
// Encode or check-and-correct one word: parity XOR trees and a one-hot flip.
// ----------------------------------------------------------------------------
module hsc_core (
	input  hsc_pkg::cfg_t            cfg,
	input  hsc_pkg::cmd_t            cmd,
	input  logic [hsc_pkg::CW_W-1:0] word_in,
	output hsc_pkg::result_t         result
);
	import hsc_pkg::*;

	logic [DATA_W-1:0] data_mask;
	logic [CW_W-1:0]   n_mask;
	logic [CW_W-1:0]   enc_raw;
	logic [SYN_W-1:0]  enc_syn;
	logic [CW_W-1:0]   enc_cw;
	logic [CW_W-1:0]   dec_in;
	logic [SYN_W-1:0]  dec_syn;
	logic              dec_err;
	logic              dec_oor;
	logic [CW_W-1:0]   dec_flip;

	// Masks for the active data and codeword lengths
	assign data_mask = DATA_W'((32'h1 << cfg.m) - 32'h1);
	assign n_mask    = CW_W'((32'h1 << cfg.n) - 32'h1);

	// Encode: scatter data, then fill parity from the data-only syndrome
	assign enc_raw = spread_data(word_in[DATA_W-1:0] & data_mask);
	assign enc_syn = syndrome_of(enc_raw);
	assign enc_cw  = (enc_raw | place_parity(enc_syn)) & n_mask;

	// Decode: syndrome, range check and single-bit correction
	assign dec_in   = word_in & n_mask;
	assign dec_syn  = syndrome_of(dec_in);
	assign dec_err  = (dec_syn != '0);
	assign dec_oor  = (dec_syn > cfg.n);
	assign dec_flip = (dec_err && !dec_oor) ? (CW_W'(1) << (dec_syn - SYN_W'(1))) : '0;

	// Select the result for the command
	always_comb begin
		result.parity_count = cfg.r;
		case (cmd)
			CMD_ENCODE: begin
				result.codeword     = enc_cw;
				result.syndrome     = '0;
				result.error_found  = 1'b0;
				result.syndrome_oor = 1'b0;
			end
			CMD_DECODE: begin
				result.codeword     = dec_in ^ dec_flip;
				result.syndrome     = dec_syn;
				result.error_found  = dec_err;
				result.syndrome_oor = dec_oor;
			end
			default: begin
				result.codeword     = '0;
				result.syndrome     = '0;
				result.error_found  = 1'b0;
				result.syndrome_oor = 1'b0;
			end
		endcase
	end

endmodule

FILE: hdl/hamming_sec_codec_top.sv
// ----------------------------------------------------------------------------
// hamming_sec_codec_top
// Hamming single-error-correcting codec, 1..26 data bits, streaming ports.
//
//   channel   direction  handshake            payload
//   s_*       in         s_tvalid/s_tready    s_tdata word_in, s_tuser cmd
//   m_*       out        m_tvalid/m_tready    m_tdata codeword..parity_count
//   cfg_*     in         cfg_we               cfg_wdata data_bits
//
// One item per cycle sustained while m_tready stays high; an item passes the input
// register, then the result register, with the encode/decode XOR trees in between.
// Reset clears both stage valid bits and sets data_bits to 4.
// A stalled result holds the result register; the input register still
// takes an item while either register is empty or the result moves on.
// ----------------------------------------------------------------------------
module hamming_sec_codec_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [hsc_pkg::IN_TDATA_W-1:0]  s_tdata,  // [30:0] word_in, [31] zero
	input  logic                            s_tuser,  // [0] cmd
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [hsc_pkg::OUT_TDATA_W-1:0] m_tdata,  // [30:0] codeword, [35:31] syndrome,
	                                                  // [36] error_found,
	                                                  // [37] syndrome_out_of_range,
	                                                  // [40:38] parity_count, [47:41] zero
	input  logic                            cfg_we,
	input  logic [hsc_pkg::CFG_W-1:0]       cfg_wdata
);
	import hsc_pkg::*;

	cfg_t            cfg;
	logic            valid_s1;
	cmd_t            cmd_s1;
	logic [CW_W-1:0] word_s1;
	logic            valid_s2;
	result_t         res_s2;
	result_t         res_next;
	logic            adv_s2;
	logic            in_acc;

	hsc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	hsc_core u_core (
		.cfg     (cfg),
		.cmd     (cmd_s1),
		.word_in (word_s1),
		.result  (res_next)
	);

	// Stage advance: result register free or being drained
	assign adv_s2   = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv_s2;
	assign in_acc   = s_tvalid && s_tready;

	// Input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// Input stage payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1  <= cmd_t'(s_tuser);
			word_s1 <= s_tdata[CW_W-1:0];
		end
	end

	// Result stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// Result stage payload
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			res_s2 <= res_next;
		end
	end

	// Pack the result item
	assign m_tvalid = valid_s2;
	assign m_tdata  = {OUT_PAD_W'(0), res_s2.parity_count, res_s2.syndrome_oor,
	                   res_s2.error_found, res_s2.syndrome, res_s2.codeword};

`ifndef NO_ASSERTIONS
	// An out-of-range syndrome is always also an error
	a_oor_implies_err: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.syndrome_oor |-> res_s2.error_found)
		else $error("syndrome out of range without error flag");

	// Error flag matches a nonzero syndrome
	a_err_matches_syn: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (res_s2.error_found == (res_s2.syndrome != '0)))
		else $error("error flag disagrees with syndrome");

	// Parity count stays within the supported code sizes
	a_pc_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (res_s2.parity_count >= PC_W'(2) && res_s2.parity_count <= PC_W'(5)))
		else $error("parity count out of range");

	// Codeword bits at and above n are zero
	a_cw_masked: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((res_s2.codeword >> cfg.n) == '0))
		else $error("codeword bits beyond length");

	// A held input item moves on once the result register is free
	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv_s2 |=> valid_s2)
		else $error("input stage item not advanced");
`endif

endmodule
